### hw/rtl/ggc_pkg.sv
// shared widths, constants and the arctangent table of the go-to-goal controller
package ggc_pkg;

	// cordic datapath widths
	localparam int DW     = 33; // robot-to-goal offset, q17.16
	localparam int XW     = 44; // cordic x/y with 8 guard bits and gain headroom
	localparam int ZW     = 32; // angles, radians in q.29
	localparam int GW     = 42; // distance with guard bits
	localparam int DIST_W = 34; // distance, q18.16
	localparam int ATAN_IDX_W = 5;

	// shared multiplier
	localparam int MA_W = 34;
	localparam int MB_W = 36;
	localparam int PW   = MA_W + MB_W;

	localparam int GUARD_BITS = 8;

	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131497;
	localparam logic [30:0] PI_Q29       = 31'd1686629713;
	localparam logic signed [ZW-1:0] HALF_PI_Q29 = 32'sd843314856;

	typedef enum logic [1:0] {
		REG_LINEAR_GAIN    = 2'd0,
		REG_ANGULAR_GAIN   = 2'd1,
		REG_ARRIVAL_RADIUS = 2'd2
	} cfg_reg_t;

	// atan(2^-idx) in q.29, rounded
	function automatic logic [28:0] atan_q29(input logic [ATAN_IDX_W-1:0] idx);
		logic [28:0] r;
		unique case (idx) inside
			5'd0: r = 29'd421657428;
			5'd1: r = 29'd248918915;
			5'd2: r = 29'd131521918;
			5'd3: r = 29'd66762579;
			5'd4: r = 29'd33510843;
			5'd5: r = 29'd16771758;
			5'd6: r = 29'd8387925;
			5'd7: r = 29'd4194219;
			5'd8: r = 29'd2097141;
			5'd9: r = 29'd1048575;
			[5'd10:5'd28]: r = 29'd1 << (5'd29 - idx);
			5'd29, 5'd30: r = 29'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// clamp to the signed 32-bit range
	function automatic logic [31:0] sat32(input logic signed [PW-1:0] v);
		logic [31:0] r;
		if (v > PW'(32'sh7fffffff))
			r = 32'h7fffffff;
		else if (v < PW'(signed'(32'h80000000)))
			r = 32'h80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

### hw/rtl/go_to_goal_controller.sv
// go-to-goal proportional controller: cordic distance/bearing and gain stage
// tick: after the input transfer come the heading multiply, the cordic loop, both halves of the
// gain correction, the linear and angular gains and the output slot, which waits on m_tready;
// a pose on the goal skips the loop and the correction; no new tick is taken until the result is loaded
// a set-goal transfer gives no result
// arst_n clears gains to 1.0/0.8, radius and goal to zero, the reached latch and the output valid
module go_to_goal_controller #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,

	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,  // target_x, target_y, pos_x, pos_y, orientation_z
	input  logic [0:0]   s_tuser,  // func

	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,  // linear_velocity, angular_velocity, goal_reached, zero pad

	// configuration writes
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_index,
	input  logic [30:0]  cfg_wdata
);

	localparam int StepW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,    // heading multiply, cordic setup with quarter turn
		S_CORDIC,  // one vectoring iteration per cycle
		S_MUL_LO,  // low half of the gain correction
		S_MUL_HI,  // high half of the gain correction
		S_LIN,     // linear gain
		S_ANG,     // angular gain on the unwrapped error
		S_OUT      // wait for the output slot, update latch
	} state_t;

	state_t state_q;

	// configuration and goal
	logic [15:0]        lin_gain_q;
	logic [15:0]        ang_gain_q;
	logic [30:0]        radius_q;
	logic signed [31:0] goal_x_q;
	logic signed [31:0] goal_y_q;
	logic               latch_q;

	// working registers
	logic signed [ggc_pkg::DW-1:0]   dx_q;
	logic signed [ggc_pkg::DW-1:0]   dy_q;
	logic signed [15:0]              oz_q;
	logic signed [ggc_pkg::ZW-1:0]   heading_q;
	logic signed [ggc_pkg::XW-1:0]   x_q;
	logic signed [ggc_pkg::XW-1:0]   y_q;
	logic signed [ggc_pkg::ZW-1:0]   z_q;
	logic [StepW-1:0]                step_q;
	logic [31:0]                     plo_q;
	logic [ggc_pkg::GW-1:0]          g_q;
	logic [ggc_pkg::DIST_W-1:0]      dist_q;
	logic [31:0]                     lin_q;
	logic [31:0]                     ang_q;

	// output register
	logic        m_valid_q;
	logic [31:0] lin_out_q;
	logic [31:0] ang_out_q;
	logic        reached_out_q;

	// input field unpack
	logic               func;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [15:0] orientation_z;

	assign func          = s_tuser[0];
	assign target_x      = s_tdata[31:0];
	assign target_y      = s_tdata[63:32];
	assign pos_x         = s_tdata[95:64];
	assign pos_y         = s_tdata[127:96];
	assign orientation_z = s_tdata[143:128];

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, reached_out_q, ang_out_q, lin_out_q};

	// cordic setup: offset scaled by the guard bits, quarter turn into the right half plane
	logic signed [ggc_pkg::XW-1:0] x_init;
	logic signed [ggc_pkg::XW-1:0] y_init;
	logic                          on_goal;

	assign x_init  = ggc_pkg::XW'(dx_q) <<< ggc_pkg::GUARD_BITS;
	assign y_init  = ggc_pkg::XW'(dy_q) <<< ggc_pkg::GUARD_BITS;
	assign on_goal = (dx_q == '0) && (dy_q == '0);

	// one cordic iteration
	logic signed [ggc_pkg::XW-1:0]   x_shr;
	logic signed [ggc_pkg::XW-1:0]   y_shr;
	logic [ggc_pkg::ATAN_IDX_W-1:0]  atan_idx;
	logic signed [ggc_pkg::ZW-1:0]   atan_step;

	assign x_shr     = x_q >>> step_q;
	assign y_shr     = y_q >>> step_q;
	assign atan_idx  = (ggc_pkg::ATAN_IDX_W)'(step_q);
	assign atan_step = ggc_pkg::ZW'(ggc_pkg::atan_q29(atan_idx));

	// magnitude split for the gain correction
	logic [ggc_pkg::XW-1:0]    mag;
	logic [ggc_pkg::XW-17:0]   mag_hi;
	logic [15:0]               mag_lo;

	assign mag    = x_q[ggc_pkg::XW-1] ? '0 : x_q;
	assign mag_hi = mag[ggc_pkg::XW-1:16];
	assign mag_lo = mag[15:0];

	// distance with guard bits removed, rounded half up
	logic [ggc_pkg::GW:0]       g_rnd;
	logic [ggc_pkg::DIST_W-1:0] dist_c;

	assign g_rnd  = {1'b0, g_q} + (ggc_pkg::GW + 1)'(1 << (ggc_pkg::GUARD_BITS - 1));
	assign dist_c = ggc_pkg::DIST_W'(g_rnd >> ggc_pkg::GUARD_BITS);

	// unwrapped heading error
	logic signed [ggc_pkg::ZW:0] err;

	assign err = {z_q[ggc_pkg::ZW-1], z_q} - {heading_q[ggc_pkg::ZW-1], heading_q};

	// shared multiplier, operands picked by the sequencer
	logic signed [ggc_pkg::MA_W-1:0] mul_a;
	logic signed [ggc_pkg::MB_W-1:0] mul_b;
	logic signed [ggc_pkg::PW-1:0]   prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_HEAD: begin
				mul_a = ggc_pkg::MA_W'(oz_q);
				mul_b = ggc_pkg::MB_W'(ggc_pkg::PI_Q29);
			end
			S_MUL_LO: begin
				mul_a = ggc_pkg::MA_W'(ggc_pkg::INV_GAIN_Q32);
				mul_b = ggc_pkg::MB_W'(mag_lo);
			end
			S_MUL_HI: begin
				mul_a = ggc_pkg::MA_W'(ggc_pkg::INV_GAIN_Q32);
				mul_b = ggc_pkg::MB_W'(mag_hi);
			end
			S_LIN: begin
				mul_a = ggc_pkg::MA_W'(lin_gain_q);
				mul_b = ggc_pkg::MB_W'(dist_c);
			end
			S_ANG: begin
				mul_a = ggc_pkg::MA_W'(ang_gain_q);
				mul_b = ggc_pkg::MB_W'(err);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// post-multiply arithmetic
	logic [60:0]                   hi_sum;
	logic signed [ggc_pkg::PW-1:0] lin_rnd;
	logic signed [ggc_pkg::PW-1:0] ang_rnd;

	assign hi_sum  = prod[60:0] + 61'(plo_q);
	assign lin_rnd = prod + ggc_pkg::PW'(128);
	assign ang_rnd = prod + ggc_pkg::PW'(32'sd1048576);

	// latch is set when the tick ends inside the arrival radius
	logic reached_next;

	assign reached_next = latch_q || (dist_q < ggc_pkg::DIST_W'(radius_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_valid_q  <= 1'b0;
			latch_q    <= 1'b0;
			lin_gain_q <= 16'd256;
			ang_gain_q <= 16'd205;
			radius_q   <= '0;
			goal_x_q   <= '0;
			goal_y_q   <= '0;
		end else begin
			// result leaves on its transfer, unless a new one is loaded in the same cycle
			if (m_valid_q && m_tready && (state_q != S_OUT))
				m_valid_q <= 1'b0;

			// register writes, expected only while idle
			if (cfg_wr_en) begin
				unique case (cfg_index)
					ggc_pkg::REG_LINEAR_GAIN:    lin_gain_q <= cfg_wdata[15:0];
					ggc_pkg::REG_ANGULAR_GAIN:   ang_gain_q <= cfg_wdata[15:0];
					ggc_pkg::REG_ARRIVAL_RADIUS: radius_q   <= cfg_wdata;
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (!func) begin
							// new goal, no result
							goal_x_q <= target_x;
							goal_y_q <= target_y;
							latch_q  <= 1'b0;
						end else begin
							dx_q    <= {goal_x_q[31], goal_x_q} - {pos_x[31], pos_x};
							dy_q    <= {goal_y_q[31], goal_y_q} - {pos_y[31], pos_y};
							oz_q    <= orientation_z;
							state_q <= S_HEAD;
						end
					end
				end

				S_HEAD: begin
					heading_q <= ggc_pkg::ZW'(prod >>> 15);
					step_q    <= '0;
					if (x_init < 0) begin
						if (y_init >= 0) begin
							x_q <= y_init;
							y_q <= -x_init;
							z_q <= ggc_pkg::HALF_PI_Q29;
						end else begin
							x_q <= -y_init;
							y_q <= x_init;
							z_q <= -ggc_pkg::HALF_PI_Q29;
						end
					end else begin
						x_q <= x_init;
						y_q <= y_init;
						z_q <= '0;
					end
					// robot on the goal: distance and bearing stay zero
					if (on_goal) begin
						g_q     <= '0;
						state_q <= S_LIN;
					end else begin
						state_q <= S_CORDIC;
					end
				end

				S_CORDIC: begin
					if (!y_q[ggc_pkg::XW-1]) begin
						x_q <= x_q + y_shr;
						y_q <= y_q - x_shr;
						z_q <= z_q + atan_step;
					end else begin
						x_q <= x_q - y_shr;
						y_q <= y_q + x_shr;
						z_q <= z_q - atan_step;
					end
					if (step_q == StepW'(CORDIC_STEPS - 1))
						state_q <= S_MUL_LO;
					else
						step_q <= step_q + StepW'(1);
				end

				S_MUL_LO: begin
					plo_q   <= prod[47:16];
					state_q <= S_MUL_HI;
				end

				S_MUL_HI: begin
					g_q     <= ggc_pkg::GW'(hi_sum >> 16);
					state_q <= S_LIN;
				end

				S_LIN: begin
					dist_q  <= dist_c;
					lin_q   <= ggc_pkg::sat32(lin_rnd >>> 8);
					state_q <= S_ANG;
				end

				S_ANG: begin
					ang_q   <= ggc_pkg::sat32(ang_rnd >>> 21);
					state_q <= S_OUT;
				end

				S_OUT: begin
					// hold until the output register is free
					if (!m_valid_q || m_tready) begin
						m_valid_q     <= 1'b1;
						lin_out_q     <= latch_q ? '0 : lin_q;
						ang_out_q     <= latch_q ? '0 : ang_q;
						reached_out_q <= reached_next;
						latch_q       <= reached_next;
						state_q       <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
